>>> hdl/morse_word_beacon_top_defines.svh
// assertion macros used by the beacon top rtl
`ifndef MORSE_WORD_BEACON_TOP_DEFINES_SVH
`define MORSE_WORD_BEACON_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// property checked on every rising clock edge outside reset
`define MWB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define MWB_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define MWB_ASSERT(label, prop, msg)
`define MWB_ASSERT_NEVER(label, cond, msg)

`endif

`endif

>>> hdl/mwb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mwb_pkg;

	// sequencer phases
	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_SEND  = 2'd1,
		PH_WAIT  = 2'd2
	} phase_t;

	// register map indexes (byte address is 8 times the index)
	typedef enum logic [2:0] {
		REG_DOT     = 3'd0,
		REG_RESTART = 3'd1,
		REG_START   = 3'd2,
		REG_BLINK   = 3'd3,
		REG_LENGTH  = 3'd4,
		REG_LETTERS = 3'd5
	} reg_idx_t;

	localparam int WORD_W   = 60;
	localparam int LETTER_W = 5;
	localparam int BUS_W    = 64;
	localparam int ADDR_W   = 6;

	localparam logic [15:0] DOT_RESET     = 16'd400;
	localparam logic [15:0] RESTART_RESET = 16'd2000;
	localparam logic [15:0] START_RESET   = 16'd4000;
	localparam logic [15:0] BLINK_RESET   = 16'd1000;
	localparam logic [3:0]  LENGTH_RESET  = 4'd1;

	// sequencer control state passed between top and step logic
	typedef struct packed {
		phase_t     phase;
		logic       blink;
		logic [3:0] letter;
		logic [2:0] symbol;
		logic       lamp;
	} mwb_ctrl_t;

	// morse pattern of one letter: symbol count and dash mask (bit i = symbol i)
	typedef struct packed {
		logic [2:0] len;
		logic [3:0] dash;
	} morse_t;

	function automatic morse_t morse_lookup(input logic [LETTER_W-1:0] code);
		morse_t m;
		m = '{len: 3'd0, dash: 4'h0};
		case (code)
			5'd0:  m = '{len: 3'd2, dash: 4'h2};
			5'd1:  m = '{len: 3'd4, dash: 4'h1};
			5'd2:  m = '{len: 3'd4, dash: 4'h5};
			5'd3:  m = '{len: 3'd3, dash: 4'h1};
			5'd4:  m = '{len: 3'd1, dash: 4'h0};
			5'd5:  m = '{len: 3'd4, dash: 4'h4};
			5'd6:  m = '{len: 3'd3, dash: 4'h3};
			5'd7:  m = '{len: 3'd4, dash: 4'h0};
			5'd8:  m = '{len: 3'd2, dash: 4'h0};
			5'd9:  m = '{len: 3'd4, dash: 4'hE};
			5'd10: m = '{len: 3'd3, dash: 4'h5};
			5'd11: m = '{len: 3'd4, dash: 4'h2};
			5'd12: m = '{len: 3'd2, dash: 4'h3};
			5'd13: m = '{len: 3'd2, dash: 4'h1};
			5'd14: m = '{len: 3'd3, dash: 4'h7};
			5'd15: m = '{len: 3'd4, dash: 4'h6};
			5'd16: m = '{len: 3'd4, dash: 4'hB};
			5'd17: m = '{len: 3'd3, dash: 4'h2};
			5'd18: m = '{len: 3'd3, dash: 4'h0};
			5'd19: m = '{len: 3'd1, dash: 4'h1};
			5'd20: m = '{len: 3'd3, dash: 4'h4};
			5'd21: m = '{len: 3'd4, dash: 4'h8};
			5'd22: m = '{len: 3'd3, dash: 4'h6};
			5'd23: m = '{len: 3'd4, dash: 4'h9};
			5'd24: m = '{len: 3'd4, dash: 4'hD};
			5'd25: m = '{len: 3'd4, dash: 4'h3};
			default: m = '{len: 3'd0, dash: 4'h0};
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

>>> hdl/mwb_step.sv
`timescale 1ns / 1ps
`default_nettype none

// next sequencer state for one tick
module mwb_step import mwb_pkg::*; #(
	parameter int MAX_LETTERS = 12,
	parameter int TICK_BITS   = 16
) (
	input  wire logic                                     restart,
	input  wire mwb_ctrl_t                                ctrl,
	input  wire logic [TICK_BITS+1:0]                     tick_cnt,
	input  wire logic [TICK_BITS-1:0]                     blink_cnt,
	input  wire logic [((TICK_BITS < 16) ? TICK_BITS : 16)-1:0] dot_ticks,
	input  wire logic [((TICK_BITS < 16) ? TICK_BITS : 16)-1:0] restart_ticks,
	input  wire logic [((TICK_BITS < 16) ? TICK_BITS : 16)-1:0] start_ticks,
	input  wire logic [((TICK_BITS < 16) ? TICK_BITS : 16)-1:0] blink_ticks,
	input  wire logic [3:0]                               word_length,
	input  wire logic [WORD_W-1:0]                        word_letters,
	output mwb_ctrl_t                                     ctrl_nxt,
	output logic [TICK_BITS+1:0]                          tick_cnt_nxt,
	output logic [TICK_BITS-1:0]                          blink_cnt_nxt
);

	localparam int CNT_W = TICK_BITS + 2;

	logic [CNT_W-1:0]     tick_inc;
	logic [CNT_W-1:0]     unit1;
	logic [CNT_W-1:0]     unit3;
	logic [CNT_W-1:0]     gap;
	logic [CNT_W-1:0]     dur;
	logic [TICK_BITS-1:0] blink_inc;
	logic [3:0]           eff_len;
	logic [LETTER_W-1:0]  code;
	morse_t               pat;
	logic [2:0]           sym_inc;

	// saturating tick counter and unit lengths
	assign tick_inc  = (&tick_cnt) ? tick_cnt : tick_cnt + CNT_W'(1);
	assign unit1     = CNT_W'(dot_ticks);
	assign unit3     = (unit1 << 1) + unit1;
	assign blink_inc = blink_cnt + TICK_BITS'(1);
	assign sym_inc   = ctrl.symbol + 3'd1;
	assign eff_len   = (word_length > 4'(MAX_LETTERS)) ? 4'(MAX_LETTERS) : word_length;
	assign gap       = (ctrl.symbol == 3'd0) ? unit3 : unit1;
	assign dur       = pat.dash[ctrl.symbol[1:0]] ? unit3 : unit1;
	assign pat       = morse_lookup(code);

	// current letter code
	always_comb begin
		code = '1;
		for (int i = 0; i < MAX_LETTERS; i++) begin
			if (ctrl.letter == 4'(i)) begin
				code = word_letters[LETTER_W*i +: LETTER_W];
			end
		end
	end

	// phase sequencer
	always_comb begin
		ctrl_nxt      = ctrl;
		tick_cnt_nxt  = tick_inc;
		blink_cnt_nxt = blink_cnt;
		if (restart) begin
			ctrl_nxt      = '{phase: PH_START, blink: 1'b1, letter: 4'd0,
				symbol: 3'd0, lamp: 1'b0};
			tick_cnt_nxt  = '0;
			blink_cnt_nxt = '0;
		end else begin
			unique case (ctrl.phase)
				PH_SEND: begin
					if (ctrl.letter >= eff_len) begin
						ctrl_nxt.phase = PH_WAIT;
						tick_cnt_nxt   = '0;
					end else if (ctrl.symbol >= pat.len) begin
						// letter without symbols: only its letter pause
						if (tick_inc >= unit3) begin
							ctrl_nxt.letter = ctrl.letter + 4'd1;
							ctrl_nxt.symbol = 3'd0;
							tick_cnt_nxt    = '0;
						end
					end else if (!ctrl.lamp) begin
						if (tick_inc >= gap) begin
							ctrl_nxt.lamp = 1'b1;
							tick_cnt_nxt  = '0;
						end
					end else if (tick_inc >= dur) begin
						ctrl_nxt.lamp = 1'b0;
						tick_cnt_nxt  = '0;
						if (sym_inc >= pat.len) begin
							ctrl_nxt.letter = ctrl.letter + 4'd1;
							ctrl_nxt.symbol = 3'd0;
						end else begin
							ctrl_nxt.symbol = sym_inc;
						end
					end
				end
				PH_WAIT: begin
					if (tick_inc >= CNT_W'(restart_ticks)) begin
						ctrl_nxt      = '{phase: PH_START, blink: 1'b1, letter: 4'd0,
							symbol: 3'd0, lamp: 1'b0};
						tick_cnt_nxt  = '0;
						blink_cnt_nxt = '0;
					end
				end
				default: begin
					// start phase: ring blink and start timer
					ctrl_nxt.phase = PH_START;
					blink_cnt_nxt  = blink_inc;
					if (blink_inc >= TICK_BITS'(blink_ticks)) begin
						blink_cnt_nxt  = '0;
						ctrl_nxt.blink = ~ctrl.blink;
					end
					if (tick_inc >= CNT_W'(start_ticks)) begin
						ctrl_nxt.phase = PH_SEND;
						tick_cnt_nxt   = '0;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hdl/morse_word_beacon_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Morse word beacon. Each accepted word is one time tick; one result word comes
// out per tick, so the block runs at one tick per clock cycle while the result
// channel is not stalled. A tick is held in an input register and the sequencer
// state (which doubles as the result register) is updated from it once the
// result slot is free, which raises result_valid. A stalled result holds the
// sequencer state and stalls the tick channel only while the input register is
// also full. The combinational path is the letter select and pattern lookup
// followed by the tick counter compare against the current step length.
// Configuration sits on a 64-bit APB port, register i at byte address 8*i;
// timing registers keep their low TICK_BITS bits when TICK_BITS is below 16.
`include "morse_word_beacon_top_defines.svh"

module morse_word_beacon_top import mwb_pkg::*; #(
	parameter int MAX_LETTERS = 12,
	parameter int TICK_BITS   = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [BUS_W-1:0]  pwdata,
	output logic [BUS_W-1:0]       prdata,
	output logic                   pready,
	// tick channel
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire logic              restart,
	// result channel
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic                   lamp_on,
	output logic                   ring_on,
	output logic [1:0]             phase_code,
	output logic [3:0]             letter_position
);

	localparam int CNT_W  = TICK_BITS + 2;
	localparam int UNIT_W = (TICK_BITS < 16) ? TICK_BITS : 16;

	// configuration registers
	logic [UNIT_W-1:0] dot_q, restart_ticks_q, start_q, blink_q;
	logic [3:0]        length_q;
	logic [WORD_W-1:0] letters_q;
	reg_idx_t          widx, ridx;
	logic              cfg_wr;

	// pipeline and sequencer state
	logic                 vld_s1, restart_s1, vld_s2;
	logic                 step_go;
	mwb_ctrl_t            ctrl_q, ctrl_nxt;
	logic [CNT_W-1:0]     tick_q, tick_nxt;
	logic [TICK_BITS-1:0] blink_cnt_q, blink_cnt_nxt;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign widx   = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign ridx   = reg_idx_t'(paddr[ADDR_W-1:3]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q           <= DOT_RESET[UNIT_W-1:0];
			restart_ticks_q <= RESTART_RESET[UNIT_W-1:0];
			start_q         <= START_RESET[UNIT_W-1:0];
			blink_q         <= BLINK_RESET[UNIT_W-1:0];
			length_q        <= LENGTH_RESET;
			letters_q       <= '0;
		end else if (cfg_wr) begin
			unique case (widx)
				REG_DOT:     dot_q           <= pwdata[UNIT_W-1:0];
				REG_RESTART: restart_ticks_q <= pwdata[UNIT_W-1:0];
				REG_START:   start_q         <= pwdata[UNIT_W-1:0];
				REG_BLINK:   blink_q         <= pwdata[UNIT_W-1:0];
				REG_LENGTH:  length_q        <= pwdata[3:0];
				REG_LETTERS: letters_q       <= pwdata[WORD_W-1:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (ridx)
			REG_DOT:     prdata = BUS_W'(dot_q);
			REG_RESTART: prdata = BUS_W'(restart_ticks_q);
			REG_START:   prdata = BUS_W'(start_q);
			REG_BLINK:   prdata = BUS_W'(blink_q);
			REG_LENGTH:  prdata = BUS_W'(length_q);
			REG_LETTERS: prdata = BUS_W'(letters_q);
			default:     prdata = '0;
		endcase
	end

	// handshake: a tick moves into the sequencer when the result slot is free
	assign step_go    = vld_s1 && (!vld_s2 || !result_stall);
	assign item_stall = vld_s1 && !step_go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!item_stall) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			restart_s1 <= restart;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (step_go) begin
			vld_s2 <= 1'b1;
		end else if (!result_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	mwb_step #(
		.MAX_LETTERS (MAX_LETTERS),
		.TICK_BITS   (TICK_BITS)
	) u_step (
		.restart       (restart_s1),
		.ctrl          (ctrl_q),
		.tick_cnt      (tick_q),
		.blink_cnt     (blink_cnt_q),
		.dot_ticks     (dot_q),
		.restart_ticks (restart_ticks_q),
		.start_ticks   (start_q),
		.blink_ticks   (blink_q),
		.word_length   (length_q),
		.word_letters  (letters_q),
		.ctrl_nxt      (ctrl_nxt),
		.tick_cnt_nxt  (tick_nxt),
		.blink_cnt_nxt (blink_cnt_nxt)
	);

	// sequencer state, also the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q      <= '{phase: PH_START, blink: 1'b1, letter: 4'd0,
				symbol: 3'd0, lamp: 1'b0};
			tick_q      <= '0;
			blink_cnt_q <= '0;
		end else if (step_go) begin
			ctrl_q      <= ctrl_nxt;
			tick_q      <= tick_nxt;
			blink_cnt_q <= blink_cnt_nxt;
		end
	end

	// result fields
	always_comb begin
		result_valid    = vld_s2;
		lamp_on         = ctrl_q.lamp;
		ring_on         = (ctrl_q.phase == PH_START) && ctrl_q.blink;
		phase_code      = ctrl_q.phase;
		letter_position = ctrl_q.letter;
	end

	`MWB_ASSERT(a_hold_state, !step_go |=> $stable(ctrl_q) && $stable(tick_q), "state moved without a tick")
	`MWB_ASSERT(a_symbol_range, ctrl_q.symbol <= 3'd3, "symbol index past four")
	`MWB_ASSERT(a_go_valid, step_go |=> vld_s2, "tick taken but no result shown")
	`MWB_ASSERT(a_restart, step_go && restart_s1 |=> ctrl_q.phase == PH_START && tick_q == '0 && ctrl_q.letter == 4'd0 && !ctrl_q.lamp, "restart did not begin the round")
	`MWB_ASSERT_NEVER(a_stall_empty, item_stall && !vld_s1, "stall with empty input register")

endmodule

`default_nettype wire
